@@ hw/rtl/lzw_variable_width_decoder_core_defines.svh @@
// Assertion macros shared by the decoder's checker.
`ifndef LZW_VARIABLE_WIDTH_DECODER_CORE_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define LZWD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define LZWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lzwd_pkg.sv @@
// Package: constants, codes and command type of the LZW decoder.
`timescale 1ns / 1ps
`default_nettype none
package lzwd_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int STACK_DEPTH  = 32;
    localparam int DICT_AW      = $clog2(DICT_ENTRIES);
    localparam int STK_AW       = $clog2(STACK_DEPTH);
    localparam int SCNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [11:0] CODE_CLEAR      = 12'h100;
    localparam logic [11:0] CODE_END        = 12'h101;
    localparam logic [12:0] CODE_FIRST_FREE = 13'h102;
    localparam logic [12:0] CODE_LIMIT      = 13'h1000;
    localparam logic [11:0] CODE_MAX_BYTE   = 12'h0ff;
    localparam logic [3:0]  WIDTH_MIN       = 4'd9;
    localparam logic [3:0]  WIDTH_MAX       = 4'd12;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_END,
        CMD_ERR,
        CMD_EXP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [11:0] code;
        logic [11:0] prev;
        logic [11:0] wr_addr;
        logic        wr_en;
        logic        unseen;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WALK,
        BK_WAIT,
        BK_EMIT,
        BK_EXTRA
    } bk_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/lzwd_ifs.sv @@
// Handshake interfaces for compressed input and decompressed output items.
`timescale 1ns / 1ps
`default_nettype none
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_stream;
    modport source (output valid, in_byte, start_of_stream, input ready);
    modport sink (input valid, in_byte, start_of_stream, output ready);
endinterface

interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
    logic [1:0] status;
    modport source (output valid, out_byte, last_of_run, end_of_stream, status,
                    input ready);
    modport sink (input valid, out_byte, last_of_run, end_of_stream, status,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lzw_variable_width_decoder_core.sv @@
// The front unpacks each byte; in the back, a chain step that reads the dictionary
// passes through BK_WALK, then BK_WAIT. The front takes up to 1 byte/cycle while the
// queue is not full; the back emits 1 result/cycle after its walk while the output
// is not stalled. A code is dequeued, walked, then emitted; a truncated string keeps 32 bytes.
// The dictionary's single read port paces the chain walk (read, then next prefix).
// Reset (rst_n low, async) clears control state; the dictionary is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lzw_variable_width_decoder_core
    import lzwd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lzwd_in_if.sink    comp,
    lzwd_out_if.source decomp
);
    // front -> queue -> back; the queue lets unpacking run ahead of a long walk
    logic q_push, q_pop, q_empty, q_full;
    cmd_t q_cmd, q_head;

    lzwd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .comp   (comp),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    lzwd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back walks prefix chains, stacks bytes, emits each item through one output reg
    lzwd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .decomp  (decomp)
    );
endmodule
`default_nettype wire

@@ hw/rtl/lzwd_cmd_fifo.sv @@
// Small command queue between the code unpacker and the expander.
`timescale 1ns / 1ps
`default_nettype none
module lzwd_cmd_fifo
    import lzwd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);
    cmd_t             mem [FIFO_DEPTH];
    logic [FIFO_AW:0] wp_reg, wp_next, rp_reg, rp_next;

    assign empty = (wp_reg == rp_reg);
    assign full  = (wp_reg[FIFO_AW-1:0] == rp_reg[FIFO_AW-1:0]) &&
                   (wp_reg[FIFO_AW] != rp_reg[FIFO_AW]);
    assign head  = mem[rp_reg[FIFO_AW-1:0]];

    always_comb
    begin
        wp_next = wp_reg + ((push && !full) ? 1'b1 : 1'b0);
        rp_next = rp_reg + ((pop && !empty) ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wp_reg[FIFO_AW-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lzwd_front.sv @@
// Front end: bit unpacking, codeword classification, width and code tracking.
`timescale 1ns / 1ps
`default_nettype none
module lzwd_front
    import lzwd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lzwd_in_if.sink   comp,
    input  wire logic q_full,
    output logic      q_push,
    output cmd_t      q_cmd
);
    logic [23:0] bb_reg, bb_next;
    logic [4:0]  bh_reg, bh_next;
    logic [3:0]  w_reg, w_next;
    logic [12:0] nfc_reg, nfc_next;
    logic [11:0] prev_reg, prev_next;
    logic        lit_reg, lit_next;
    logic        done_reg, done_next;

    logic [23:0] bb_s, bb_app, mask;
    logic [4:0]  bh_s, bh_app;
    logic [3:0]  w_s;
    logic [12:0] nfc_s, nfc_inc;
    logic [11:0] prev_s, code;
    logic        lit_s, done_s, take;

    assign comp.ready = !q_full;
    assign take       = comp.valid && !q_full;

    always_comb
    begin
        bb_s   = comp.start_of_stream ? 24'd0 : bb_reg;
        bh_s   = comp.start_of_stream ? 5'd0 : bh_reg;
        w_s    = comp.start_of_stream ? WIDTH_MIN : w_reg;
        nfc_s  = comp.start_of_stream ? CODE_FIRST_FREE : nfc_reg;
        prev_s = comp.start_of_stream ? 12'd0 : prev_reg;
        lit_s  = comp.start_of_stream ? 1'b0 : lit_reg;
        done_s = comp.start_of_stream ? 1'b0 : done_reg;

        bb_app  = bb_s | (24'(comp.in_byte) << bh_s);
        bh_app  = bh_s + 5'd8;
        mask    = (24'd1 << w_s) - 24'd1;
        code    = 12'(bb_app & mask);
        nfc_inc = (nfc_s < CODE_LIMIT) ? nfc_s + 13'd1 : nfc_s;

        bb_next   = bb_reg;
        bh_next   = bh_reg;
        w_next    = w_reg;
        nfc_next  = nfc_reg;
        prev_next = prev_reg;
        lit_next  = lit_reg;
        done_next = done_reg;
        q_push    = 1'b0;
        q_cmd.kind    = CMD_EXP;
        q_cmd.code    = code;
        q_cmd.prev    = prev_s;
        q_cmd.wr_addr = nfc_s[DICT_AW-1:0];
        q_cmd.wr_en   = (nfc_s < 13'(DICT_ENTRIES));
        q_cmd.unseen  = ({1'b0, code} == nfc_s);

        if (take)
        begin
            bb_next   = bb_s;
            bh_next   = bh_s;
            w_next    = w_s;
            nfc_next  = nfc_s;
            prev_next = prev_s;
            lit_next  = lit_s;
            done_next = done_s;
            if (!done_s)
            begin
                bb_next = bb_app;
                bh_next = bh_app;
                if (bh_app >= 5'(w_s))
                begin
                    bb_next = bb_app >> w_s;
                    bh_next = bh_app - 5'(w_s);
                    if (lit_s)
                    begin
                        lit_next   = 1'b0;
                        prev_next  = {4'd0, code[7:0]};
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_LIT;
                    end
                    else if (code == CODE_CLEAR)
                    begin
                        w_next   = WIDTH_MIN;
                        nfc_next = CODE_FIRST_FREE;
                        lit_next = 1'b1;
                    end
                    else if (code == CODE_END)
                    begin
                        done_next  = 1'b1;
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_END;
                    end
                    else if ({1'b0, code} > nfc_s)
                    begin
                        done_next  = 1'b1;
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_ERR;
                    end
                    else
                    begin
                        q_push    = 1'b1;
                        prev_next = code;
                        nfc_next  = nfc_inc;
                        if (w_s < WIDTH_MAX && nfc_inc >= (13'd1 << w_s))
                        begin
                            w_next = w_s + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bb_reg   <= '0;
            bh_reg   <= '0;
            w_reg    <= WIDTH_MIN;
            nfc_reg  <= CODE_FIRST_FREE;
            prev_reg <= '0;
            lit_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            bb_reg   <= bb_next;
            bh_reg   <= bh_next;
            w_reg    <= w_next;
            nfc_reg  <= nfc_next;
            prev_reg <= prev_next;
            lit_reg  <= lit_next;
            done_reg <= done_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lzwd_back.sv @@
// Back end: dictionary chain walk, string stack and result output register.
`timescale 1ns / 1ps
`default_nettype none
module lzwd_back
    import lzwd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    lzwd_out_if.source decomp
);
    logic [19:0] dict [DICT_ENTRIES];
    logic [7:0]  stack [STACK_DEPTH];

    bk_state_t        st_reg, st_next;
    cmd_t             cmd_reg, cmd_next;
    logic [11:0]      c_reg, c_next;
    logic [SCNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       top_reg, top_next;
    logic             trunc_reg, trunc_next;

    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic        oe_reg, oe_next;
    logic [1:0]  os_reg, os_next;

    logic              slot_free;
    logic [DICT_AW-1:0] rd_addr;
    logic              rd_en;
    logic [19:0]       rd_data;
    logic              wr_en;
    logic              push;
    logic [7:0]        push_val;
    logic [7:0]        pop_val;

    assign decomp.valid         = ov_reg;
    assign decomp.out_byte      = ob_reg;
    assign decomp.last_of_run   = ol_reg;
    assign decomp.end_of_stream = oe_reg;
    assign decomp.status        = os_reg;

    assign slot_free = !ov_reg || decomp.ready;
    assign pop_val   = stack[STK_AW'(cnt_reg - 1'b1)];

    always_comb
    begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        c_next     = c_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        trunc_next = trunc_reg;
        ov_next    = ov_reg && !decomp.ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        oe_next    = oe_reg;
        os_next    = os_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = c_reg[DICT_AW-1:0];
        wr_en      = 1'b0;
        push       = 1'b0;
        push_val   = 8'd0;

        unique case (st_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == CMD_EXP)
                    begin
                        q_pop      = 1'b1;
                        cmd_next   = q_head;
                        c_next     = q_head.unseen ? q_head.prev : q_head.code;
                        cnt_next   = '0;
                        trunc_next = 1'b0;
                        st_next    = BK_WALK;
                    end
                    else if (slot_free)
                    begin
                        q_pop   = 1'b1;
                        ov_next = 1'b1;
                        ob_next = (q_head.kind == CMD_LIT) ? q_head.code[7:0] : 8'd0;
                        ol_next = 1'b1;
                        oe_next = (q_head.kind == CMD_END);
                        os_next = (q_head.kind == CMD_ERR) ? ST_UNDEF : ST_OK;
                    end
                end
            end
            BK_WALK:
            begin
                if (cnt_reg >= SCNT_W'(STACK_DEPTH))
                begin
                    trunc_next = 1'b1;
                    wr_en      = cmd_reg.wr_en;
                    st_next    = BK_EMIT;
                end
                else if (c_reg <= CODE_MAX_BYTE)
                begin
                    push     = 1'b1;
                    push_val = c_reg[7:0];
                    top_next = c_reg[7:0];
                    cnt_next = cnt_reg + 1'b1;
                    wr_en    = cmd_reg.wr_en;
                    st_next  = BK_EMIT;
                end
                else if ({1'b0, c_reg} >= 13'(DICT_ENTRIES))
                begin
                    // unstored index reads as prefix 0, byte 0
                    push     = 1'b1;
                    top_next = 8'd0;
                    cnt_next = cnt_reg + 1'b1;
                    c_next   = 12'd0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    st_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                push     = 1'b1;
                push_val = rd_data[7:0];
                top_next = rd_data[7:0];
                c_next   = rd_data[19:8];
                cnt_next = cnt_reg + 1'b1;
                st_next  = BK_WALK;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    ob_next  = pop_val;
                    ol_next  = (cnt_reg == SCNT_W'(1)) && !cmd_reg.unseen;
                    oe_next  = 1'b0;
                    os_next  = trunc_reg ? ST_TRUNC : ST_OK;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == SCNT_W'(1))
                    begin
                        st_next = cmd_reg.unseen ? BK_EXTRA : BK_IDLE;
                    end
                end
            end
            BK_EXTRA:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    ob_next = top_reg;
                    ol_next = 1'b1;
                    oe_next = 1'b0;
                    os_next = trunc_reg ? ST_TRUNC : ST_OK;
                    st_next = BK_IDLE;
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    // dictionary: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dict[cmd_reg.wr_addr[DICT_AW-1:0]] <= {cmd_reg.prev, top_next};
        end
        if (rd_en)
        begin
            rd_data <= dict[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack[cnt_reg[STK_AW-1:0]] <= push_val;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        c_reg     <= c_next;
        top_reg   <= top_next;
        trunc_reg <= trunc_next;
        ob_reg    <= ob_next;
        ol_reg    <= ol_next;
        oe_reg    <= oe_next;
        os_reg    <= os_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= BK_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lzwd_checker.sv @@
// Port-level checker for the decoder output, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_variable_width_decoder_core_defines.svh"
module lzwd_checker
    import lzwd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run,
    input wire logic       end_of_stream,
    input wire logic [1:0] status
);
    `LZWD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "valid dropped")
    `LZWD_ASSERT_NOW(a_end, clk, rst_n, out_valid && end_of_stream, last_of_run && out_byte == 8'd0 && status == ST_OK, "bad end item")
    `LZWD_ASSERT_NOW(a_err, clk, rst_n, out_valid && status == ST_UNDEF, last_of_run && out_byte == 8'd0 && !end_of_stream, "bad error item")
    `LZWD_ASSERT_NOW(a_st, clk, rst_n, out_valid, status == ST_OK || status == ST_UNDEF || status == ST_TRUNC, "bad status")
endmodule

bind lzw_variable_width_decoder_core lzwd_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (decomp.valid),
    .out_ready     (decomp.ready),
    .out_byte      (decomp.out_byte),
    .last_of_run   (decomp.last_of_run),
    .end_of_stream (decomp.end_of_stream),
    .status        (decomp.status)
);
`default_nettype wire

@@ test/lzw_variable_width_decoder_core_test.sv @@
// Self-checking testbench for the variable-width LZW decoder core.
`timescale 1ns / 1ps
`default_nettype none
module lzw_variable_width_decoder_core_test;
    import lzwd_pkg::*;

    // Result item fields as the decoder should produce them.
    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_stream;
        logic [1:0] status;
    } result_t;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int ITEM_TARGET = 320;

    logic clk;
    logic rst_n;

    lzwd_in_if  comp ();
    lzwd_out_if decomp ();

    lzw_variable_width_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .comp   (comp.sink),
        .decomp (decomp.source)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Decoded bytes still owed by the block, oldest first.
    result_t pending_bytes[$];

    int cycles;
    int mismatches;
    int items_sent;
    int results_seen;
    int streams_sent;
    int truncated_seen;
    int errors_seen;
    int ends_seen;

    // ---------------------------------------------------------------
    // Decoder predictor: its own copy of the unpacker and dictionary.
    // ---------------------------------------------------------------
    logic [23:0] bits_acc;
    int          bits_in;
    int          width_now;
    int          free_code;
    logic [11:0] last_code;
    bit          literal_due;
    bit          halted;
    logic [19:0] dict_mirror [DICT_ENTRIES];
    logic [7:0]  chain_bytes [STACK_DEPTH];
    int          chain_len;

    task automatic restart_decoder();
        bits_acc    = '0;
        bits_in     = 0;
        width_now   = WIDTH_MIN;
        free_code   = CODE_FIRST_FREE;
        last_code   = '0;
        literal_due = 1'b0;
        halted      = 1'b0;
        chain_len   = 0;
    endtask

    task automatic owe(logic [7:0] b, logic eos, logic [1:0] st);
        result_t r;
        r.out_byte      = b;
        r.last_of_run   = 1'b0;
        r.end_of_stream = eos;
        r.status        = st;
        pending_bytes.push_back(r);
    endtask

    task automatic decode_byte(logic [7:0] b, logic sos);
        logic [31:0] wide;
        logic [11:0] code;
        logic [11:0] c;
        logic [19:0] entry;
        logic [7:0]  top;
        logic [1:0]  st;
        bit          unseen;
        bit          cut;
        if (sos)
            restart_decoder();
        if (halted)
            return;
        wide = {8'h00, bits_acc} | ({24'h0, b} << bits_in);
        bits_acc = wide[23:0];
        bits_in += 8;
        if (bits_in < width_now)
            return;
        code = 12'(bits_acc & ((24'h1 << width_now) - 1));
        bits_acc = bits_acc >> width_now;
        bits_in -= width_now;

        if (literal_due)
        begin
            literal_due = 1'b0;
            last_code = {4'h0, code[7:0]};
            owe(code[7:0], 1'b0, ST_OK);
            pending_bytes[pending_bytes.size()-1].last_of_run = 1'b1;
            return;
        end
        if (code == CODE_CLEAR)
        begin
            width_now   = WIDTH_MIN;
            free_code   = CODE_FIRST_FREE;
            literal_due = 1'b1;
            return;
        end
        if (code == CODE_END || int'(code) > free_code)
        begin
            halted = 1'b1;
            if (code == CODE_END)
            begin
                owe(8'h00, 1'b1, ST_OK);
                ends_seen++;
            end
            else
            begin
                owe(8'h00, 1'b0, ST_UNDEF);
                errors_seen++;
            end
            pending_bytes[pending_bytes.size()-1].last_of_run = 1'b1;
            return;
        end

        // Walk the prefix chain, tail byte first; stop when the stack fills.
        unseen = (int'(code) == free_code);
        c = unseen ? last_code : code;
        chain_len = 0;
        cut = 1'b0;
        while (c > CODE_MAX_BYTE && !cut)
        begin
            if (chain_len >= STACK_DEPTH)
                cut = 1'b1;
            else
            begin
                entry = (int'(c) < DICT_ENTRIES) ? dict_mirror[c] : '0;
                chain_bytes[chain_len] = entry[7:0];
                chain_len++;
                c = entry[19:8];
            end
        end
        if (!cut)
        begin
            if (chain_len >= STACK_DEPTH)
                cut = 1'b1;
            else
            begin
                chain_bytes[chain_len] = c[7:0];
                chain_len++;
            end
        end
        st = cut ? ST_TRUNC : ST_OK;
        if (cut)
            truncated_seen++;
        top = chain_bytes[chain_len-1];
        for (int i = chain_len - 1; i >= 0; i--)
            owe(chain_bytes[i], 1'b0, st);
        if (unseen)
            owe(top, 1'b0, st);
        pending_bytes[pending_bytes.size()-1].last_of_run = 1'b1;

        // New entry: previous string plus first byte of this one.
        if (free_code < DICT_ENTRIES)
            dict_mirror[free_code] = {last_code, top};
        if (free_code < CODE_LIMIT)
            free_code++;
        if (width_now < WIDTH_MAX && free_code >= (1 << width_now))
            width_now++;
        last_code = code;
    endtask

    // ---------------------------------------------------------------
    // Stream builder: packs codes LSB first, tracking the code width
    // the decoder will be using when it reaches each code.
    // ---------------------------------------------------------------
    logic [7:0]  packed_bytes[$];
    logic [31:0] pack_acc;
    int          pack_bits;
    int          enc_width;
    int          enc_free;
    bit          enc_literal;

    task automatic begin_stream();
        packed_bytes.delete();
        pack_acc    = '0;
        pack_bits   = 0;
        enc_width   = WIDTH_MIN;
        enc_free    = CODE_FIRST_FREE;
        enc_literal = 1'b0;
    endtask

    task automatic put_code(int code);
        pack_acc |= (32'(code) & ((32'h1 << enc_width) - 1)) << pack_bits;
        pack_bits += enc_width;
        while (pack_bits >= 8)
        begin
            packed_bytes.push_back(pack_acc[7:0]);
            pack_acc = pack_acc >> 8;
            pack_bits -= 8;
        end
        if (enc_literal)
            enc_literal = 1'b0;
        else if (code == CODE_CLEAR)
        begin
            enc_width   = WIDTH_MIN;
            enc_free    = CODE_FIRST_FREE;
            enc_literal = 1'b1;
        end
        else if (code != CODE_END && code <= enc_free)
        begin
            if (enc_free < CODE_LIMIT)
                enc_free++;
            if (enc_width < WIDTH_MAX && enc_free >= (1 << enc_width))
                enc_width++;
        end
    endtask

    // A code that is defined right now: a byte, a stored entry, or the next one.
    function automatic int valid_code();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4 || enc_free == CODE_FIRST_FREE)
            return $urandom_range(0, 255);
        else if (pick < 8)
            return $urandom_range(CODE_FIRST_FREE, enc_free - 1);
        else
            return (enc_free < CODE_LIMIT) ? enc_free : $urandom_range(0, 255);
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length with random gaps between them.
    // ---------------------------------------------------------------
    int burst_left;

    task automatic send_item(logic [7:0] b, logic sos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                comp.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        decode_byte(b, sos);
        comp.valid           <= 1'b1;
        comp.in_byte         <= b;
        comp.start_of_stream <= sos;
        do
            @(posedge clk);
        while (!(comp.valid && comp.ready));
        items_sent++;
    endtask

    task automatic pause_sender();
        comp.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic flush_stream(int extra);
        if (pack_bits > 0)
            packed_bytes.push_back(pack_acc[7:0]);
        repeat (extra)
            packed_bytes.push_back(8'($urandom));
        foreach (packed_bytes[i])
            send_item(packed_bytes[i], i == 0);
        streams_sent++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern that cycles through several moods.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        case ((cycles / 300) % 4)
            0: decomp.ready <= 1'b1;
            1: decomp.ready <= ($urandom_range(0, 3) != 0);
            2: decomp.ready <= ((cycles % 11) < 3);
            default: decomp.ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // ---------------------------------------------------------------
    // Result checker.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && decomp.valid && decomp.ready)
        begin
            results_seen++;
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %h last %b end %b status %0d",
                             decomp.out_byte, decomp.last_of_run,
                             decomp.end_of_stream, decomp.status);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (decomp.out_byte !== want.out_byte
                    || decomp.last_of_run !== want.last_of_run
                    || decomp.end_of_stream !== want.end_of_stream
                    || decomp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected byte %h last %b end %b status %0d,",
                                  " got byte %h last %b end %b status %0d"},
                                 results_seen, want.out_byte, want.last_of_run,
                                 want.end_of_stream, want.status, decomp.out_byte,
                                 decomp.last_of_run, decomp.end_of_stream, decomp.status);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_bytes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------

    // Byte extremes, clear then literal (9-bit literal, low byte kept), code equal
    // to next free, clear as literal, undefined code; end code, trailing bytes ignored.
    task automatic test_basic_codes();
        begin_stream();
        put_code(8'h00);
        put_code(8'hff);
        put_code(CODE_FIRST_FREE);
        put_code(CODE_CLEAR);
        put_code(12'h1ab);
        put_code(12'h041);
        put_code(CODE_FIRST_FREE);
        put_code(CODE_FIRST_FREE + 1);
        put_code(CODE_CLEAR);
        put_code(CODE_CLEAR);
        put_code(12'h1ff);
        put_code(CODE_END);
        flush_stream(3);
    endtask

    // Chain of ever-longer strings until the stack overflows.
    task automatic test_long_strings();
        begin_stream();
        put_code(CODE_CLEAR);
        put_code(12'h061);
        for (int i = 0; i < 36; i++)
            put_code(enc_free);
        put_code(CODE_FIRST_FREE + 33);
        put_code(CODE_FIRST_FREE + 20);
        put_code(CODE_END);
        flush_stream(0);
    endtask

    // Code above next free raises the error and halts the stream.
    task automatic test_undefined_code();
        begin_stream();
        put_code(8'h10);
        put_code(CODE_FIRST_FREE);
        put_code(CODE_FIRST_FREE + 2);
        put_code(12'h020);
        flush_stream(4);
        begin_stream();
        put_code(8'h80);
        put_code(12'h1ff);
        flush_stream(2);
    endtask

    // Start of stream arriving in the middle of a stream.
    task automatic test_restart_midstream();
        begin_stream();
        for (int i = 0; i < 6; i++)
            put_code(valid_code());
        flush_stream(0);
        send_item(8'h5a, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'hff, 1'b0);
        send_item(8'h03, 1'b0);
    endtask

    // Random well-formed streams with some broken ones and loose noise,
    // until the whole run has sent about the planned number of bytes.
    task automatic test_random_streams();
        int n_codes;
        int roll;
        while (items_sent < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 19);
            if (roll < 2)
            begin
                for (int i = 0; i < 8; i++)
                    send_item(8'($urandom), $urandom_range(0, 5) == 0);
            end
            else
            begin
                begin_stream();
                n_codes = $urandom_range(3, 30);
                for (int i = 0; i < n_codes; i++)
                begin
                    if (enc_literal)
                        put_code($urandom_range(0, 511));
                    else if ($urandom_range(0, 15) == 0)
                        put_code(CODE_CLEAR);
                    else
                        put_code(valid_code());
                end
                if (roll == 2 && enc_free < (1 << enc_width) - 1 && !enc_literal)
                    put_code($urandom_range(enc_free + 1, (1 << enc_width) - 1));
                else if (roll < 16)
                    put_code(CODE_END);
                flush_stream($urandom_range(0, 2));
            end
            if ($urandom_range(0, 5) == 0)
                pause_sender();
        end
    endtask

    initial
    begin
        cycles               = 0;
        mismatches           = 0;
        items_sent           = 0;
        results_seen         = 0;
        streams_sent         = 0;
        truncated_seen       = 0;
        errors_seen          = 0;
        ends_seen            = 0;
        burst_left           = 0;
        comp.valid           = 1'b0;
        comp.in_byte         = '0;
        comp.start_of_stream = 1'b0;
        decomp.ready         = 1'b0;
        rst_n                = 1'b0;
        restart_decoder();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_codes();
        test_long_strings();
        test_undefined_code();
        test_restart_midstream();
        test_random_streams();

        comp.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d streams, %0d results checked, %0d mismatches",
                 items_sent, streams_sent, results_seen, mismatches);
        $display("end codes %0d, undefined codes %0d, truncated strings %0d",
                 ends_seen, errors_seen, truncated_seen);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_ifs.sv
hw/rtl/lzwd_cmd_fifo.sv
hw/rtl/lzwd_front.sv
hw/rtl/lzwd_back.sv
hw/rtl/lzw_variable_width_decoder_core.sv
hw/rtl/lzwd_checker.sv
test/lzw_variable_width_decoder_core_test.sv
